>>> hdl/tbc_pkg.sv
// ----------------------------------------------------------------------------
// tbc_pkg: shared types and constants for the barycentric coordinate block
// Widths of the front and divider stages are derived here from the coordinate and
// fraction widths.
// ----------------------------------------------------------------------------
`default_nettype none

package tbc_pkg;

  localparam int IN_W       = 12;
  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam int W_W        = 24;

  localparam int EB = COORD_BITS + 1;
  localparam int PB = 2 * EB;
  localparam int DB = PB + 2;
  localparam int DP = 2 * DB;
  localparam int MB = DP + 1;
  localparam int UB = MB - 1;
  localparam int IB = 2 * EB + 2;
  localparam int QB = IB + FRAC_BITS;

  typedef logic [2:0][IN_W-1:0] tbc_vec_t;

  typedef struct packed {
    tbc_vec_t c;
    tbc_vec_t b;
    tbc_vec_t a;
    tbc_vec_t p;
  } tbc_coords_t;

  typedef struct packed {
    logic          degen;
    logic          neg_v;
    logic          neg_w;
    logic [UB-1:0] ud;
    logic [UB-1:0] unv;
    logic [UB-1:0] unw;
  } tbc_item_t;

  typedef struct packed {
    logic           sat;
    logic           degen;
    logic [W_W-1:0] w;
    logic [W_W-1:0] v;
    logic [W_W-1:0] u;
  } tbc_result_t;

endpackage

`default_nettype wire

>>> hdl/triangle_barycentric_coords.sv
// ----------------------------------------------------------------------------
// triangle_barycentric_coords: barycentric weights of a point in a triangle
//
// The slave stream carries one query point and three corners per beat; the
// master stream returns one beat per input beat with weights u, v, w in signed
// fixed point with 16 fraction bits and the degenerate and saturated flags.
// A new beat is taken every cycle while the receiver keeps up. A result
// passes through the five-stage arithmetic front, the queue, and the back
// end with a load stage and one stage for each of 44 quotient bits, followed
// by a sign stage and the clamp and output register.
// When the receiver holds tready low the back end freezes with its result on
// the port; the front keeps taking beats until the two-entry queue is full
// and its last stage holds a beat, then drops s_axis_tready. Reset clears
// all valid flags; no result is offered afterward until a new beat arrives.
// ----------------------------------------------------------------------------
`default_nettype none

module triangle_barycentric_coords import tbc_pkg::*; (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // point x,y,z, corner a x,y,z, corner b x,y,z, corner c x,y,z; 12 bits each
  input  wire logic [143:0] s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // weight_u, weight_v, weight_w; 24 bits each
  output logic [71:0]       m_axis_tdata,
  // degenerate, saturated
  output logic [1:0]        m_axis_tuser
);

  tbc_coords_t coords;
  tbc_item_t   f_item, q_item;
  tbc_result_t res;
  logic        f_valid, q_ready, q_valid, q_pop, b_valid;

  assign coords = tbc_coords_t'(s_axis_tdata);

  tbc_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .coords_i (coords),
    .valid_o  (f_valid),
    .ready_i  (q_ready),
    .item_o   (f_item)
  );

  tbc_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (f_valid && q_ready),
    .item_i  (f_item),
    .ready_o (q_ready),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .item_o  (q_item)
  );

  tbc_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (q_valid),
    .pop_o    (q_pop),
    .item_i   (q_item),
    .valid_o  (b_valid),
    .ready_i  (m_axis_tready),
    .result_o (res)
  );

  assign m_axis_tvalid = b_valid;
  assign m_axis_tdata  = {res.w, res.v, res.u};
  assign m_axis_tuser  = {res.sat, res.degen};

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> (m_axis_tdata == '0) && !m_axis_tuser[1])
    else $error("degenerate result with nonzero weights or saturation");

  a_sat_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |->
      (m_axis_tdata[23:0] == 24'h7FFFFF) || (m_axis_tdata[23:0] == 24'h800000) ||
      (m_axis_tdata[47:24] == 24'h7FFFFF) || (m_axis_tdata[47:24] == 24'h800000) ||
      (m_axis_tdata[71:48] == 24'h7FFFFF) || (m_axis_tdata[71:48] == 24'h800000))
    else $error("saturated flag without a clamped weight");

  a_front_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_valid && !q_ready |=> f_valid && $stable(f_item))
    else $error("front item lost while the queue was full");

  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid && (b_valid == 1'b0 || m_axis_tready))
    else $error("queue popped while the back end was stalled");

endmodule

`default_nettype wire

>>> hdl/tbc_front.sv
// ----------------------------------------------------------------------------
// tbc_front: edge vectors, dot products, determinant and numerators
// Five stall-together stages; the last one classifies the triangle and hands
// sign and magnitude operands to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module tbc_front import tbc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        valid_i,
  output logic             ready_o,
  input  wire tbc_coords_t coords_i,
  output logic             valid_o,
  input  wire logic        ready_i,
  output tbc_item_t        item_o
);

  typedef logic signed [EB-1:0] evec_t [3];

  function automatic logic signed [EB-1:0] sx(input logic [IN_W-1:0] r);
    sx = EB'($signed(r[COORD_BITS-1:0]));
  endfunction

  logic adv;
  logic va_q, vb_q, vc_q, vd_q, ve_q;

  evec_t e0_q, e1_q, e2_q;
  logic signed [PB-1:0] pr_q [5][3];
  logic signed [DB-1:0] dt_q [5];
  logic signed [DP-1:0] pd_q [6];
  logic signed [MB-1:0] den_q, nv_q, nw_q;

  assign adv     = !ve_q || ready_i;
  assign ready_o = adv;
  assign valid_o = ve_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (adv) begin
      va_q <= valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= vc_q;
      ve_q <= vd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        e0_q[k] <= sx(coords_i.b[k]) - sx(coords_i.a[k]);
        e1_q[k] <= sx(coords_i.c[k]) - sx(coords_i.a[k]);
        e2_q[k] <= sx(coords_i.p[k]) - sx(coords_i.a[k]);
        pr_q[0][k] <= PB'(e0_q[k]) * PB'(e0_q[k]);
        pr_q[1][k] <= PB'(e0_q[k]) * PB'(e1_q[k]);
        pr_q[2][k] <= PB'(e1_q[k]) * PB'(e1_q[k]);
        pr_q[3][k] <= PB'(e2_q[k]) * PB'(e0_q[k]);
        pr_q[4][k] <= PB'(e2_q[k]) * PB'(e1_q[k]);
      end
      for (int j = 0; j < 5; j++) begin
        dt_q[j] <= DB'(pr_q[j][0]) + DB'(pr_q[j][1]) + DB'(pr_q[j][2]);
      end
      pd_q[0] <= DP'(dt_q[0]) * DP'(dt_q[2]);
      pd_q[1] <= DP'(dt_q[1]) * DP'(dt_q[1]);
      pd_q[2] <= DP'(dt_q[2]) * DP'(dt_q[3]);
      pd_q[3] <= DP'(dt_q[1]) * DP'(dt_q[4]);
      pd_q[4] <= DP'(dt_q[0]) * DP'(dt_q[4]);
      pd_q[5] <= DP'(dt_q[1]) * DP'(dt_q[3]);
      den_q <= MB'(pd_q[0]) - MB'(pd_q[1]);
      nv_q  <= MB'(pd_q[2]) - MB'(pd_q[3]);
      nw_q  <= MB'(pd_q[4]) - MB'(pd_q[5]);
    end
  end

  logic signed [MB-1:0] den_abs, nv_abs, nw_abs;

  always_comb begin
    den_abs      = den_q[MB-1] ? -den_q : den_q;
    nv_abs       = nv_q[MB-1] ? -nv_q : nv_q;
    nw_abs       = nw_q[MB-1] ? -nw_q : nw_q;
    item_o.degen = (den_q == '0);
    item_o.neg_v = nv_q[MB-1] ^ den_q[MB-1];
    item_o.neg_w = nw_q[MB-1] ^ den_q[MB-1];
    item_o.ud    = den_abs[UB-1:0];
    item_o.unv   = nv_abs[UB-1:0];
    item_o.unw   = nw_abs[UB-1:0];
  end

endmodule

`default_nettype wire

>>> hdl/tbc_queue.sv
// ----------------------------------------------------------------------------
// tbc_queue: two-entry queue between the front and back pipelines
// Lets either side stall on its own without losing a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module tbc_queue import tbc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      push_i,
  input  wire tbc_item_t item_i,
  output logic           ready_o,
  input  wire logic      pop_i,
  output logic           valid_o,
  output tbc_item_t      item_o
);

  tbc_item_t  mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign item_o  = mem_q[rd_ptr_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 2'd1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

>>> hdl/tbc_back.sv
// ----------------------------------------------------------------------------
// tbc_back: pipelined division, weight assembly and saturation
// Two restoring dividers run side by side, one quotient bit per stage, then
// signs are applied, u is formed and all weights are clamped, or zeroed for a degenerate triangle.
// ----------------------------------------------------------------------------
`default_nettype none

module tbc_back import tbc_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      valid_i,
  output logic           pop_o,
  input  wire tbc_item_t item_i,
  output logic           valid_o,
  input  wire logic      ready_i,
  output tbc_result_t    result_o
);

  localparam int XW = QB + 3;
  localparam logic signed [XW-1:0] WMAX = XW'(24'sh7FFFFF);
  localparam logic signed [XW-1:0] WMIN = XW'(24'sh800000);
  localparam logic signed [XW-1:0] ONE  = XW'(2 ** FRAC_BITS);

  typedef struct packed {
    logic          degen;
    logic          neg_v;
    logic          neg_w;
    logic [UB-1:0] ud;
    logic [UB-1:0] rv;
    logic [UB-1:0] rw;
    logic [QB-1:0] mqv;
    logic [QB-1:0] mqw;
  } div_t;

  typedef struct packed {
    logic [UB-1:0] r;
    logic [QB-1:0] mq;
  } part_t;

  function automatic part_t div_step(input logic [UB-1:0] r, input logic [QB-1:0] mq,
                                     input logic [UB-1:0] d);
    logic [UB:0] t;
    logic [UB:0] diff;
    logic        ge;
    part_t       res;
    t        = {r, mq[QB-1]};
    diff     = t - {1'b0, d};
    ge       = (t >= {1'b0, d});
    res.r    = ge ? diff[UB-1:0] : t[UB-1:0];
    res.mq   = {mq[QB-2:0], ge};
    div_step = res;
  endfunction

  function automatic logic [W_W:0] clamp_w(input logic signed [XW-1:0] x);
    logic [W_W:0] res;
    if (x > WMAX) begin
      res = {1'b1, WMAX[W_W-1:0]};
    end else if (x < WMIN) begin
      res = {1'b1, WMIN[W_W-1:0]};
    end else begin
      res = {1'b0, x[W_W-1:0]};
    end
    clamp_w = res;
  endfunction

  logic adv;
  logic [QB:0] vs_q;
  div_t        st_q [QB+1];
  logic        vf_q, degf_q, vo_q;
  logic signed [QB:0] vf_val_q, wf_val_q;
  tbc_result_t res_q;

  assign adv      = !vo_q || ready_i;
  assign pop_o    = adv && valid_i;
  assign valid_o  = vo_q;
  assign result_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vs_q <= '0;
      vf_q <= 1'b0;
      vo_q <= 1'b0;
    end else if (adv) begin
      vs_q <= {vs_q[QB-1:0], valid_i};
      vf_q <= vs_q[QB];
      vo_q <= vf_q;
    end
  end

  part_t pv [QB];
  part_t pw [QB];
  logic signed [QB:0] qv_s, qw_s;
  logic signed [XW-1:0] ux, vx, wx;
  logic [W_W:0] cu, cv, cw;

  always_comb begin
    for (int k = 0; k < QB; k++) begin
      pv[k] = div_step(st_q[k].rv, st_q[k].mqv, st_q[k].ud);
      pw[k] = div_step(st_q[k].rw, st_q[k].mqw, st_q[k].ud);
    end
    qv_s = $signed({1'b0, st_q[QB].mqv});
    qw_s = $signed({1'b0, st_q[QB].mqw});
    vx   = XW'(vf_val_q);
    wx   = XW'(wf_val_q);
    ux   = ONE - vx - wx;
    cu   = clamp_w(ux);
    cv   = clamp_w(vx);
    cw   = clamp_w(wx);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      st_q[0].degen <= item_i.degen;
      st_q[0].neg_v <= item_i.neg_v;
      st_q[0].neg_w <= item_i.neg_w;
      st_q[0].ud    <= item_i.ud;
      st_q[0].rv    <= UB'(item_i.unv >> IB);
      st_q[0].rw    <= UB'(item_i.unw >> IB);
      st_q[0].mqv   <= {item_i.unv[IB-1:0], FRAC_BITS'(0)};
      st_q[0].mqw   <= {item_i.unw[IB-1:0], FRAC_BITS'(0)};
      for (int k = 0; k < QB; k++) begin
        st_q[k+1].degen <= st_q[k].degen;
        st_q[k+1].neg_v <= st_q[k].neg_v;
        st_q[k+1].neg_w <= st_q[k].neg_w;
        st_q[k+1].ud    <= st_q[k].ud;
        st_q[k+1].rv    <= pv[k].r;
        st_q[k+1].rw    <= pw[k].r;
        st_q[k+1].mqv   <= pv[k].mq;
        st_q[k+1].mqw   <= pw[k].mq;
      end
      degf_q   <= st_q[QB].degen;
      vf_val_q <= st_q[QB].neg_v ? -qv_s : qv_s;
      wf_val_q <= st_q[QB].neg_w ? -qw_s : qw_s;
      if (degf_q) begin
        res_q <= '{sat: 1'b0, degen: 1'b1, w: '0, v: '0, u: '0};
      end else begin
        res_q.sat   <= cu[W_W] | cv[W_W] | cw[W_W];
        res_q.degen <= 1'b0;
        res_q.u     <= cu[W_W-1:0];
        res_q.v     <= cv[W_W-1:0];
        res_q.w     <= cw[W_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/tb_bary_checker.sv
// ----------------------------------------------------------------------------
// tb_bary_checker: scoreboard for the barycentric coordinate block
// Watches both streams, computes the expected weights and flags of every
// accepted input beat, and compares each output beat with the oldest one.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bary_checker (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  input  wire logic         s_axis_tready,
  input  wire logic [143:0] s_axis_tdata,
  input  wire logic         m_axis_tvalid,
  input  wire logic         m_axis_tready,
  input  wire logic [71:0]  m_axis_tdata,
  input  wire logic [1:0]   m_axis_tuser,
  output int                fail_count_o,
  output int                pending_o
);

  typedef struct packed {
    logic        sat;
    logic        degen;
    logic [23:0] w;
    logic [23:0] v;
    logic [23:0] u;
  } weights_t;

  weights_t exp_mem [256];
  int       wr_cnt_q = 0;
  int       rd_cnt_q = 0;

  function automatic longint coord(logic [143:0] d, int idx);
    logic signed [11:0] c;
    c = d[idx*12 +: 12];
    return longint'(c);
  endfunction

  function automatic longint frac_div(longint num, longint den);
    logic neg;
    longint un, ud, q, r;
    neg = (num < 0) != (den < 0);
    un = num < 0 ? -num : num;
    ud = den < 0 ? -den : den;
    q = un / ud;
    r = un % ud;
    if (q > (64'sd1 <<< 30)) q = 64'sd1 <<< 30;
    for (int i = 0; i < 16; i++) begin
      r = r <<< 1;
      q = q <<< 1;
      if (r >= ud) begin
        r -= ud;
        q |= 1;
      end
    end
    return neg ? -q : q;
  endfunction

  function automatic logic [23:0] clamp(longint x, inout logic sat);
    if (x > 8388607) begin
      sat = 1'b1;
      x = 8388607;
    end else if (x < -8388608) begin
      sat = 1'b1;
      x = -8388608;
    end
    return x[23:0];
  endfunction

  function automatic weights_t barycentric(logic [143:0] d);
    longint e0[3], e1[3], e2[3];
    longint d00, d01, d11, d20, d21, den, v, w;
    weights_t r;
    d00 = 0; d01 = 0; d11 = 0; d20 = 0; d21 = 0;
    for (int k = 0; k < 3; k++) begin
      e0[k] = coord(d, 6 + k) - coord(d, 3 + k);
      e1[k] = coord(d, 9 + k) - coord(d, 3 + k);
      e2[k] = coord(d, k) - coord(d, 3 + k);
      d00 += e0[k] * e0[k];
      d01 += e0[k] * e1[k];
      d11 += e1[k] * e1[k];
      d20 += e2[k] * e0[k];
      d21 += e2[k] * e1[k];
    end
    den = d00 * d11 - d01 * d01;
    r = '0;
    if (den == 0) begin
      r.degen = 1'b1;
      return r;
    end
    v = frac_div(d11 * d20 - d01 * d21, den);
    w = frac_div(d00 * d21 - d01 * d20, den);
    r.u = clamp(65536 - v - w, r.sat);
    r.v = clamp(v, r.sat);
    r.w = clamp(w, r.sat);
    return r;
  endfunction

  assign pending_o = wr_cnt_q - rd_cnt_q;

  always @(posedge clk_i or negedge rst_ni) begin
    weights_t e;
    if (!rst_ni) begin
      fail_count_o <= 0;
      wr_cnt_q     <= 0;
      rd_cnt_q     <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        exp_mem[wr_cnt_q[7:0]] <= barycentric(s_axis_tdata);
        wr_cnt_q <= wr_cnt_q + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (wr_cnt_q == rd_cnt_q) begin
          $error("output beat with nothing expected");
          fail_count_o <= fail_count_o + 1;
        end else begin
          e = exp_mem[rd_cnt_q[7:0]];
          rd_cnt_q <= rd_cnt_q + 1;
          if (m_axis_tdata[23:0] !== e.u)
            $error("weight_u exp %h got %h", e.u, m_axis_tdata[23:0]);
          if (m_axis_tdata[47:24] !== e.v)
            $error("weight_v exp %h got %h", e.v, m_axis_tdata[47:24]);
          if (m_axis_tdata[71:48] !== e.w)
            $error("weight_w exp %h got %h", e.w, m_axis_tdata[71:48]);
          if (m_axis_tuser[0] !== e.degen)
            $error("degenerate exp %b got %b", e.degen, m_axis_tuser[0]);
          if (m_axis_tuser[1] !== e.sat)
            $error("saturated exp %b got %b", e.sat, m_axis_tuser[1]);
          if ({m_axis_tuser[1:0], m_axis_tdata} !== {e.sat, e.degen, e.w, e.v, e.u})
            fail_count_o <= fail_count_o + 1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the barycentric coordinate block
// Drives directed triangles (extremes, degenerate and saturating cases), then
// random ones with random gaps and output stalls, and reports the outcome.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [143:0] s_axis_tdata = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [71:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;
  int           fail_count, pending;
  int           idle_cycles = 0;

  always #4 clk_i = ~clk_i;

  triangle_barycentric_coords u_dut (.*);

  tb_bary_checker u_chk (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  function automatic logic [143:0] pack12(int v[12]);
    logic [143:0] d;
    for (int i = 0; i < 12; i++) d[i*12 +: 12] = v[i][11:0];
    return d;
  endfunction

  function automatic logic [143:0] random_triangle();
    int v[12];
    int span;
    span = $urandom_range(0, 3) == 0 ? 2047 : (1 << $urandom_range(1, 11)) - 1;
    for (int i = 0; i < 12; i++) v[i] = $urandom_range(0, 2 * span) - span;
    case ($urandom_range(0, 9))
      0: for (int i = 0; i < 3; i++) v[6 + i] = v[3 + i];
      1: for (int i = 0; i < 3; i++) v[9 + i] = 2 * v[6 + i] - v[3 + i];
      2: for (int i = 0; i < 3; i++) v[i] = v[3 + i] + $urandom_range(0, 4) - 2;
      3: return 144'({$urandom, $urandom, $urandom, $urandom, $urandom});
      default: ;
    endcase
    return pack12(v);
  endfunction

  task automatic send(logic [143:0] d);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= d;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  initial begin
    int rx_gap;
    forever begin
      rx_gap = $urandom_range(0, 19);
      if (rx_gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (rx_gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("tb failed");
      $finish;
    end
  end

  initial begin
    int v[12];
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send('0);
    send({144{1'b1}});
    send({12{12'h800}});
    send({12{12'h7ff}});
    v = '{0, 0, 0, -2048, -2048, -2048, 2047, -2048, 0, -2048, 2047, 2047};
    send(pack12(v));
    v = '{2047, 2047, -2048, -2048, -2048, -2048, 2047, -2048, 0, -2048, 2047, 2047};
    send(pack12(v));
    v = '{0, 0, 0, 0, 0, 0, 1, 0, 0, 0, 1, 0};
    send(pack12(v));
    v = '{-2048, 2047, -2048, 0, 0, 0, 1, 0, 0, 0, 1, 0};
    send(pack12(v));
    v = '{0, 0, 0, 0, 0, 0, 1, 1, 1, 2, 2, 2};
    send(pack12(v));
    v = '{-2048, -2048, 2047, 0, 0, 0, 2047, 0, 0, 0, 1, 0};
    send(pack12(v));
    v = '{1, 1, 0, 0, 0, 0, 3, 0, 0, 0, 3, 0};
    send(pack12(v));
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    for (int n = 0; n < 1000; n++) begin
      if (n == 500) begin
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
      end
      send(random_triangle());
    end
    s_axis_tvalid <= 1'b0;
    wait (pending == 0);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("tb passed");
    else
      $display("tb failed");
    $finish;
  end

endmodule

`default_nettype wire

>>> sim.f
hdl/tbc_pkg.sv
hdl/tbc_front.sv
hdl/tbc_queue.sv
hdl/tbc_back.sv
hdl/triangle_barycentric_coords.sv
tb/tb_bary_checker.sv
tb/tb.sv
